FILE: rtl/temp_sensor_poll_check_convert_core_assert.svh
// ----------------------------------------------------------------------------
// Temperature poll core assertion macros
// Shared property forms for the checker of the temperature poll core.
// ----------------------------------------------------------------------------
`ifndef TEMP_SENSOR_POLL_CHECK_CONVERT_CORE_ASSERT_SVH
`define TEMP_SENSOR_POLL_CHECK_CONVERT_CORE_ASSERT_SVH

// same-cycle implication
`define TSPCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tspcc: same-cycle check failed");

// next-cycle implication
`define TSPCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tspcc: next-cycle check failed");

`endif

FILE: rtl/tspcc_pkg.sv
// ----------------------------------------------------------------------------
// Temperature poll core package
// Widths, codes, register reset values and shared structs.
// ----------------------------------------------------------------------------
package tspcc_pkg;

    localparam int PTR_W      = 8;
    localparam int WORD_W     = 16;
    localparam int DEG_W      = 8;
    localparam int FRAC_W     = 4;
    localparam int COUNTS_W   = 16;
    localparam int PHASE_W    = 2;
    localparam int FAULT_W    = 3;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // temperature word layout
    localparam logic [FRAC_W-1:0] FMT_MASK = 4'hF;
    localparam int DEG_LSB    = 8;
    localparam int FRAC_LSB   = 4;

    // conversion: ((deg + 50) * 4096 + frac * 256) / 250
    localparam int DEG_OFFSET  = 50;
    localparam int DEG_SHIFT   = 12;
    localparam int FRAC_SHIFT  = 8;
    localparam int NUM_W       = 22;
    localparam int N_W         = 20;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 21'd1073742;
    localparam int PROD_W      = N_W + RECIP_W;

    typedef enum logic [PHASE_W-1:0] {
        PH_WR_CFG_PTR  = 2'd0,
        PH_RD_CFG      = 2'd1,
        PH_WR_TEMP_PTR = 2'd2,
        PH_RD_TEMP     = 2'd3
    } t_phase;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE         = 3'd0,
        FAULT_CFG_PTR      = 3'd1,
        FAULT_CFG_MISMATCH = 3'd2,
        FAULT_TEMP_PTR     = 3'd3,
        FAULT_FORMAT       = 3'd4,
        FAULT_RANGE        = 3'd5
    } t_fault;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CONFIG_POINTER  = 3'd0,
        REG_TEMP_POINTER    = 3'd1,
        REG_EXPECTED_CONFIG = 3'd2,
        REG_ALERT_MASK      = 3'd3,
        REG_MIN_DEGREES     = 3'd4,
        REG_MAX_DEGREES     = 3'd5,
        REG_INITIAL_COUNTS  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [PTR_W-1:0]    config_pointer;
        logic [PTR_W-1:0]    temp_pointer;
        logic [WORD_W-1:0]   expected_config;
        logic [WORD_W-1:0]   alert_mask;
        logic [DEG_W-1:0]    min_degrees;
        logic [DEG_W-1:0]    max_degrees;
        logic [COUNTS_W-1:0] initial_counts;
    } t_cfg;

    localparam logic [COUNTS_W-1:0] INITIAL_COUNTS_RST = 16'd0;

    localparam t_cfg CFG_RESET = '{
        config_pointer:  8'd1,
        temp_pointer:    8'd0,
        expected_config: 16'd24736,
        alert_mask:      16'd32,
        min_degrees:     8'hCE,
        max_degrees:     8'd126,
        initial_counts:  INITIAL_COUNTS_RST
    };

    typedef struct packed {
        logic [PTR_W-1:0]    pointer_out;
        t_fault              fault;
        logic [COUNTS_W-1:0] counts;
    } t_calc;

endpackage

FILE: rtl/tspcc_if.sv
// ----------------------------------------------------------------------------
// Temperature poll core channels
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tspcc_step_if;
    import tspcc_pkg::*;
    logic                valid;
    logic                ready;
    logic                transfer_ok;
    logic [WORD_W-1:0]   read_word;
    modport source (output valid, transfer_ok, read_word, input ready);
    modport sink   (input valid, transfer_ok, read_word, output ready);
endinterface

interface tspcc_res_if;
    import tspcc_pkg::*;
    logic                valid;
    logic                ready;
    logic [PHASE_W-1:0]  phase_done;
    logic [PTR_W-1:0]    pointer_out;
    logic [COUNTS_W-1:0] temperature_counts;
    logic [FAULT_W-1:0]  fault;
    modport source (output valid, phase_done, pointer_out, temperature_counts, fault,
                    input ready);
    modport sink   (input valid, phase_done, pointer_out, temperature_counts, fault,
                    output ready);
endinterface

interface tspcc_cfg_if;
    import tspcc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tspcc_cfg.sv
// ----------------------------------------------------------------------------
// Temperature poll core register file
// Holds the pointer, check, range and initial-counts registers written over the config port.
// ----------------------------------------------------------------------------
module tspcc_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_valid,
    input  logic [tspcc_pkg::REG_IDX_W-1:0]      i_wr_index,
    input  logic [tspcc_pkg::CFG_DATA_W-1:0]     i_wr_data,
    output tspcc_pkg::t_cfg                      o_cfg,
    output logic                                 o_load_initial
);
    import tspcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg          = r_cfg;
        o_load_initial = 1'b0;
        if (i_wr_valid) begin
            case (t_reg_idx'(i_wr_index))
                REG_CONFIG_POINTER:  n_cfg.config_pointer  = i_wr_data[PTR_W-1:0];
                REG_TEMP_POINTER:    n_cfg.temp_pointer    = i_wr_data[PTR_W-1:0];
                REG_EXPECTED_CONFIG: n_cfg.expected_config = i_wr_data[WORD_W-1:0];
                REG_ALERT_MASK:      n_cfg.alert_mask      = i_wr_data[WORD_W-1:0];
                REG_MIN_DEGREES:     n_cfg.min_degrees     = i_wr_data[DEG_W-1:0];
                REG_MAX_DEGREES:     n_cfg.max_degrees     = i_wr_data[DEG_W-1:0];
                REG_INITIAL_COUNTS: begin
                    n_cfg.initial_counts = i_wr_data[COUNTS_W-1:0];
                    o_load_initial       = 1'b1;
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/tspcc_calc.sv
// ----------------------------------------------------------------------------
// Temperature poll core step logic
// Checks one request against its phase and converts a good temperature word.
// ----------------------------------------------------------------------------
module tspcc_calc (
    input  tspcc_pkg::t_phase                    i_phase,
    input  logic                                 i_transfer_ok,
    input  logic [tspcc_pkg::WORD_W-1:0]         i_read_word,
    input  tspcc_pkg::t_cfg                      i_cfg,
    input  logic [tspcc_pkg::COUNTS_W-1:0]       i_held,
    output tspcc_pkg::t_calc                     o_calc
);
    import tspcc_pkg::*;

    logic signed [DEG_W-1:0] deg;
    logic [FRAC_W-1:0]       frac;
    logic [NUM_W-1:0]        deg_off;
    logic [NUM_W-1:0]        num;
    logic [N_W-1:0]          num_sat;
    logic [PROD_W-1:0]       prod;
    logic [COUNTS_W-1:0]     conv;
    logic                    fmt_bad;
    logic                    range_bad;

    assign deg     = $signed(i_read_word[DEG_LSB +: DEG_W]);
    assign frac    = i_read_word[FRAC_LSB +: FRAC_W];
    assign deg_off = {{(NUM_W-DEG_W){deg[DEG_W-1]}}, deg} + NUM_W'(DEG_OFFSET);
    assign num     = (deg_off << DEG_SHIFT) + (NUM_W'(frac) << FRAC_SHIFT);
    assign num_sat = num[NUM_W-1] ? '0 : num[N_W-1:0];
    assign prod    = PROD_W'(num_sat) * PROD_W'(RECIP_MULT);
    assign conv    = prod[RECIP_SHIFT +: COUNTS_W];

    assign fmt_bad   = (i_read_word[FRAC_W-1:0] & FMT_MASK) != '0;
    assign range_bad = (deg < $signed(i_cfg.min_degrees))
                    || (deg > $signed(i_cfg.max_degrees));

    always_comb begin
        o_calc.pointer_out = '0;
        o_calc.fault       = FAULT_NONE;
        o_calc.counts      = i_held;
        case (i_phase)
            PH_WR_CFG_PTR: begin
                o_calc.pointer_out = i_cfg.config_pointer;
                if (!i_transfer_ok) begin
                    o_calc.fault = FAULT_CFG_PTR;
                end
            end
            PH_RD_CFG: begin
                if ((i_read_word | i_cfg.alert_mask) != i_cfg.expected_config) begin
                    o_calc.fault = FAULT_CFG_MISMATCH;
                end
            end
            PH_WR_TEMP_PTR: begin
                o_calc.pointer_out = i_cfg.temp_pointer;
                if (!i_transfer_ok) begin
                    o_calc.fault = FAULT_TEMP_PTR;
                end
            end
            PH_RD_TEMP: begin
                if (fmt_bad) begin
                    o_calc.fault = FAULT_FORMAT;
                end else if (range_bad) begin
                    o_calc.fault = FAULT_RANGE;
                end else begin
                    o_calc.counts = conv;
                end
            end
            default: o_calc.fault = FAULT_NONE;
        endcase
    end

endmodule

FILE: rtl/temp_sensor_poll_check_convert_core.sv
// ----------------------------------------------------------------------------
// Temperature poll core
// Four-phase sensor poll sequencer with config check, temperature format and
// range check, and conversion to ADC-equivalent counts.
//
//   channel   modport  carries
//   i_step    sink     transfer_ok, read_word (one scheduler step)
//   o_result  source   phase_done, pointer_out, temperature_counts, fault
//   i_cfg     sink     index, data (register write, always ready)
//
// One request per cycle while the result is not stalled; each passes the request register, then the result register.
// Request register feeds the check/convert logic, whose one multiplier
// (divide by 250) sets the critical path into the result register.
// A stalled result holds; the request register then fills and ready drops.
// Synchronous active-low reset: phase 0, held value from initial_counts.
// ----------------------------------------------------------------------------
module temp_sensor_poll_check_convert_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tspcc_step_if.sink  i_step,
    tspcc_res_if.source o_result,
    tspcc_cfg_if.sink   i_cfg
);
    import tspcc_pkg::*;

    t_cfg                cfg;
    logic                load_initial;
    t_calc               calc;

    logic                r_s1_valid;
    logic                r_s1_ok;
    logic [WORD_W-1:0]   r_s1_word;

    logic                r_out_valid;
    t_phase              r_out_phase;
    logic [PTR_W-1:0]    r_out_ptr;
    logic [COUNTS_W-1:0] r_out_counts;
    t_fault              r_out_fault;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [COUNTS_W-1:0] r_held;

    logic                out_free;
    logic                s1_adv;
    logic                step_acc;

    tspcc_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_valid     (i_cfg.valid),
        .i_wr_index     (i_cfg.index),
        .i_wr_data      (i_cfg.data),
        .o_cfg          (cfg),
        .o_load_initial (load_initial)
    );

    tspcc_calc u_calc (
        .i_phase       (r_phase),
        .i_transfer_ok (r_s1_ok),
        .i_read_word   (r_s1_word),
        .i_cfg         (cfg),
        .i_held        (r_held),
        .o_calc        (calc)
    );

    assign i_cfg.ready  = 1'b1;
    assign out_free     = !r_out_valid || o_result.ready;
    assign s1_adv       = r_s1_valid && out_free;
    assign i_step.ready = !r_s1_valid || out_free;
    assign step_acc     = i_step.valid && i_step.ready;
    assign n_phase      = t_phase'(r_phase + 2'd1);

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_WR_CFG_PTR;
            r_held      <= INITIAL_COUNTS_RST;
        end else begin
            if (step_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_phase <= n_phase;
                r_held  <= calc.counts;
            end else if (load_initial) begin
                r_held  <= i_cfg.data[COUNTS_W-1:0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_s1_ok   <= i_step.transfer_ok;
            r_s1_word <= i_step.read_word;
        end
        if (s1_adv) begin
            r_out_phase  <= r_phase;
            r_out_ptr    <= calc.pointer_out;
            r_out_counts <= calc.counts;
            r_out_fault  <= calc.fault;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.phase_done         = r_out_phase;
    assign o_result.pointer_out        = r_out_ptr;
    assign o_result.temperature_counts = r_out_counts;
    assign o_result.fault              = r_out_fault;

endmodule

FILE: rtl/tspcc_checker.sv
// ----------------------------------------------------------------------------
// Temperature poll core checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "temp_sensor_poll_check_convert_core_assert.svh"

module tspcc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [tspcc_pkg::PHASE_W-1:0]       i_phase_done,
    input  logic [tspcc_pkg::PTR_W-1:0]         i_pointer_out,
    input  logic [tspcc_pkg::COUNTS_W-1:0]      i_temperature_counts,
    input  logic [tspcc_pkg::FAULT_W-1:0]       i_fault
);
    import tspcc_pkg::*;

    logic               res_acc;
    logic [PHASE_W-1:0] r_exp_phase;

    assign res_acc = i_res_valid && i_res_ready;

    // track the phase the next delivered result must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_phase <= PH_WR_CFG_PTR;
        end else if (res_acc) begin
            r_exp_phase <= r_exp_phase + 2'd1;
        end
    end

    `TSPCC_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_phase_done) && $stable(i_pointer_out)
        && $stable(i_temperature_counts) && $stable(i_fault))

    `TSPCC_ASSERT_NOW(a_phase_order, i_clk, i_rst_n, res_acc,
        i_phase_done == r_exp_phase)

    `TSPCC_ASSERT_NOW(a_read_no_ptr, i_clk, i_rst_n, i_res_valid && i_phase_done[0],
        i_pointer_out == '0)

    `TSPCC_ASSERT_NOW(a_fault_phase, i_clk, i_rst_n, i_res_valid && i_fault != FAULT_NONE,
        (i_phase_done == PH_WR_CFG_PTR && i_fault == FAULT_CFG_PTR)
        || (i_phase_done == PH_RD_CFG && i_fault == FAULT_CFG_MISMATCH)
        || (i_phase_done == PH_WR_TEMP_PTR && i_fault == FAULT_TEMP_PTR)
        || (i_phase_done == PH_RD_TEMP && i_fault == FAULT_FORMAT)
        || (i_phase_done == PH_RD_TEMP && i_fault == FAULT_RANGE))

endmodule

bind temp_sensor_poll_check_convert_core tspcc_checker u_tspcc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_res_valid          (o_result.valid),
    .i_res_ready          (o_result.ready),
    .i_phase_done         (o_result.phase_done),
    .i_pointer_out        (o_result.pointer_out),
    .i_temperature_counts (o_result.temperature_counts),
    .i_fault              (o_result.fault)
);
